// ===== sv/mti_pkg.sv =====
// Shared types and constants for the MLP tanh inference unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package mti_pkg;

    localparam int CNT_W     = 7;
    localparam int LAYER_W   = 4;
    localparam int IDX_W     = 9;
    localparam int VAL_W     = 16;
    localparam int OUT_IDX_W = 6;
    localparam int OUT_VAL_W = 14;
    localparam int PROD_W    = 33;
    localparam int ACC_W     = 40;

    // 1.0 in Q4.12, used as the bias operand.
    localparam logic signed [16:0] ONE_Q12 = 17'sd4096;
    // 3.0 in Q8.24: saturation threshold of the activation.
    localparam logic [ACC_W-1:0] SAT_LIMIT = 40'd50331648;
    // 27.0 in Q8.12, the constant of the rational tanh.
    localparam logic [19:0] TANH_K = 20'd110592;
    localparam logic [OUT_VAL_W-1:0] Y_MAX = 14'd4096;

    // Command passed from the front end to the back end.
    typedef struct packed {
        logic                    wr_weight;
        logic                    wr_input;
        logic                    start;
        logic [IDX_W-1:0]        addr;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAC,
        B_DRAIN,
        B_TANH,
        B_WRITE
    } t_back_state;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SQ,
        T_MUL,
        T_DIV
    } t_tanh_state;

endpackage
`default_nettype wire

// ===== sv/mti_in_if.sv =====
// Input channel of the MLP tanh inference unit: valid, ready and one item.
// Depends on mti_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mti_in_if import mti_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    last;

    modport source (output valid, func, index, value, last, input ready);
    modport sink   (input valid, func, index, value, last, output ready);
endinterface
`default_nettype wire

// ===== sv/mti_out_if.sv =====
// Result channel of the MLP tanh inference unit: valid, ready and one result.
// Depends on mti_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mti_out_if import mti_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [OUT_IDX_W-1:0]        out_index;
    logic signed [OUT_VAL_W-1:0] out_value;
    logic                        out_last;

    modport source (output valid, out_index, out_value, out_last, input ready);
    modport sink   (input valid, out_index, out_value, out_last, output ready);
endinterface
`default_nettype wire

// ===== sv/mlp_tanh_inference_unit.sv =====
// MLP tanh inference unit: top level (front end, command queue, back end, tanh).
// Throughput is one pass at a time. Weight and sample transfers pass through the command queue
// and are executed only while the back end is idle. A pass runs one multiply-accumulate per cycle
// in the MAC phase. Each neuron runs a MAC phase over its inputs and its bias, drains the multiply
// pipeline, runs the tanh (the divider is skipped when saturated) and writes back its result.
// Reset clears only the control state. The memories keep their contents and are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module mlp_tanh_inference_unit import mti_pkg::*; #(
    parameter int INPUT_COUNT  = 8,
    parameter int HIDDEN_WIDTH = 16,
    parameter int LAYER_COUNT  = 2,
    parameter int OUTPUT_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mti_in_if.sink     i_in,
    mti_out_if.source  o_out
);

    localparam int OUTPUT_BASE =
        (INPUT_COUNT + 1 + (LAYER_COUNT - 1) * (HIDDEN_WIDTH + 1)) * HIDDEN_WIDTH;
    localparam int WEIGHT_TOTAL = OUTPUT_BASE + OUTPUT_COUNT * (HIDDEN_WIDTH + 1);
    localparam int WA = $clog2(WEIGHT_TOTAL);

    t_cmd front_cmd;
    logic front_valid;
    logic fifo_ready;
    t_cmd head_cmd;
    logic head_valid;
    logic head_pop;
    logic tanh_start;
    logic signed [ACC_W-1:0] tanh_sum;
    logic tanh_done;
    logic signed [OUT_VAL_W-1:0] tanh_y;

    // Item classification.
    mti_front #(
        .INPUT_COUNT  (INPUT_COUNT),
        .WEIGHT_TOTAL (WEIGHT_TOTAL)
    ) u_front (
        .i_in        (i_in),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (fifo_ready)
    );

    // Decoupling queue.
    mti_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_ready (fifo_ready),
        .i_pop   (head_pop),
        .o_cmd   (head_cmd),
        .o_valid (head_valid)
    );

    // Command execution and forward pass.
    mti_back #(
        .INPUT_COUNT  (INPUT_COUNT),
        .HIDDEN_WIDTH (HIDDEN_WIDTH),
        .LAYER_COUNT  (LAYER_COUNT),
        .OUTPUT_COUNT (OUTPUT_COUNT),
        .WEIGHT_TOTAL (WEIGHT_TOTAL),
        .WA           (WA)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (head_valid),
        .i_cmd        (head_cmd),
        .o_cmd_pop    (head_pop),
        .o_tanh_start (tanh_start),
        .o_tanh_sum   (tanh_sum),
        .i_tanh_done  (tanh_done),
        .i_tanh_y     (tanh_y),
        .o_out        (o_out)
    );

    // Activation unit.
    mti_tanh u_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tanh_start),
        .i_sum   (tanh_sum),
        .o_done  (tanh_done),
        .o_y     (tanh_y)
    );

endmodule
`default_nettype wire

// ===== sv/mti_front.sv =====
// Front end: accepts items and turns them into back-end commands.
// Depends on mti_pkg and mti_in_if.
`timescale 1ns / 1ps
`default_nettype none
module mti_front import mti_pkg::*; #(
    parameter int INPUT_COUNT  = 8,
    parameter int WEIGHT_TOTAL = 484
) (
    mti_in_if.sink     i_in,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready
);

    logic w_ok;
    logic in_ok;
    logic start;

    // Out-of-range writes are dropped; last only counts on a sample item.
    assign w_ok  = !i_in.func && (32'(i_in.index) < WEIGHT_TOTAL);
    assign in_ok = i_in.func && (32'(i_in.index) < INPUT_COUNT);
    assign start = i_in.func && i_in.last;

    assign o_cmd.wr_weight = w_ok;
    assign o_cmd.wr_input  = in_ok;
    assign o_cmd.start     = start;
    assign o_cmd.addr      = i_in.index;
    assign o_cmd.value     = i_in.value;

    // Items that do nothing are taken and discarded.
    assign o_cmd_valid = i_in.valid && (w_ok || in_ok || start);
    assign i_in.ready  = i_cmd_ready;

endmodule
`default_nettype wire

// ===== sv/mti_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on mti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mti_cmd_fifo import mti_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_valid
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

endmodule
`default_nettype wire

// ===== sv/mti_tanh.sv =====
// Saturating rational tanh: squares, multiplies, then a bit-serial divider.
// Depends on mti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mti_tanh import mti_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [ACC_W-1:0]     i_sum,
    output logic                        o_done,
    output logic signed [OUT_VAL_W-1:0] o_y
);

    t_tanh_state r_state, n_state;
    logic                        r_neg;
    logic [14:0]                 r_x;
    logic [15:0]                 r_x2;
    logic [19:0]                 r_den;
    logic [31:0]                 r_quo;
    logic [19:0]                 r_rem;
    logic [4:0]                  r_cnt;
    logic signed [OUT_VAL_W-1:0] r_y;
    logic                        r_done;

    logic [ACC_W-1:0] mag;
    logic             sat;
    logic [29:0]      sq;
    logic [19:0]      den_c;
    logic [31:0]      num_c;
    logic [20:0]      trial;
    logic             ge;
    logic [31:0]      quo_n;
    logic [OUT_VAL_W-1:0] y_mag;

    assign mag   = i_sum[ACC_W-1] ? ACC_W'(-i_sum) : ACC_W'(i_sum);
    assign sat   = (mag >= SAT_LIMIT);
    assign sq    = 30'(r_x) * 30'(r_x);
    assign den_c = TANH_K + 20'(20'(r_x2) * 20'd9);
    assign num_c = 32'(r_x) * 32'(TANH_K + 20'(r_x2));
    assign trial = {r_rem, r_quo[31]};
    assign ge    = (trial >= {1'b0, r_den});
    assign quo_n = {r_quo[30:0], ge};
    assign y_mag = (quo_n > 32'(Y_MAX)) ? Y_MAX : quo_n[OUT_VAL_W-1:0];

    assign o_done = r_done;
    assign o_y    = r_y;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE:  if (i_start && !sat) n_state = T_SQ;
            T_SQ:    n_state = T_MUL;
            T_MUL:   n_state = T_DIV;
            T_DIV:   if (r_cnt == 5'd31) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == T_IDLE && i_start && sat) ||
                       (r_state == T_DIV && r_cnt == 5'd31);
        end
    end

    // Datapath: magnitude, square, numerator and divider steps.
    always_ff @(posedge i_clk) begin
        case (r_state)
            T_IDLE: begin
                if (i_start) begin
                    r_neg <= i_sum[ACC_W-1];
                    r_x   <= 15'((mag + 40'd2048) >> 12);
                    if (sat) r_y <= i_sum[ACC_W-1] ? -$signed(Y_MAX) : $signed(Y_MAX);
                end
            end
            T_SQ: begin
                r_x2 <= 16'(sq >> 12);
            end
            T_MUL: begin
                r_den <= den_c;
                r_quo <= num_c + 32'(den_c >> 1);
                r_rem <= 20'd0;
                r_cnt <= 5'd0;
            end
            T_DIV: begin
                r_rem <= ge ? 20'(trial - {1'b0, r_den}) : trial[19:0];
                r_quo <= quo_n;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) r_y <= r_neg ? -$signed(y_mag) : $signed(y_mag);
            end
            default: r_cnt <= 5'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/mti_back.sv =====
// Back end: runs stored commands and the layer-by-layer MAC sequencer.
// Depends on mti_pkg and mti_out_if; uses the tanh unit through its ports.
`timescale 1ns / 1ps
`default_nettype none
module mti_back import mti_pkg::*; #(
    parameter int INPUT_COUNT  = 8,
    parameter int HIDDEN_WIDTH = 16,
    parameter int LAYER_COUNT  = 2,
    parameter int OUTPUT_COUNT = 4,
    parameter int WEIGHT_TOTAL = 484,
    parameter int WA           = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  t_cmd                        i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_tanh_start,
    output logic signed [ACC_W-1:0]     o_tanh_sum,
    input  logic                        i_tanh_done,
    input  logic signed [OUT_VAL_W-1:0] i_tanh_y,
    mti_out_if.source                   o_out
);

    localparam int IW      = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int AW      = (HIDDEN_WIDTH > 1) ? $clog2(HIDDEN_WIDTH) : 1;
    localparam int L0_SIZE = (INPUT_COUNT + 1) * HIDDEN_WIDTH;
    localparam int HD_SIZE = (HIDDEN_WIDTH + 1) * HIDDEN_WIDTH;

    logic signed [VAL_W-1:0] r_wmem [WEIGHT_TOTAL];
    logic signed [VAL_W-1:0] r_imem [INPUT_COUNT];
    logic signed [VAL_W-1:0] r_amem [2 << AW];

    t_back_state r_state, n_state;
    logic [LAYER_W-1:0] r_layer, n_layer;
    logic [CNT_W-1:0]   r_row, n_row, r_col, n_col, r_rows, n_rows, r_cols, n_cols;
    logic [WA-1:0]      r_base, n_base, r_waddr, n_waddr;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    logic                     r_p1, r_p1_bias, r_p1_hid, r_p2;
    logic signed [VAL_W-1:0]  r_wq, r_iq, r_aq;
    logic signed [16:0]       src;
    logic signed [PROD_W-1:0] r_prod;

    logic                        r_out_valid;
    logic [OUT_IDX_W-1:0]        r_out_index;
    logic signed [OUT_VAL_W-1:0] r_out_value;
    logic                        r_out_last;

    logic issue;
    logic last_layer;
    logic out_load;
    logic act_we;
    logic [WA-1:0] base_next;

    assign issue      = (r_state == B_MAC);
    assign last_layer = (r_layer == LAYER_W'(LAYER_COUNT));
    assign base_next  = r_base + ((r_layer == '0) ? WA'(L0_SIZE) : WA'(HD_SIZE));
    assign o_cmd_pop  = (r_state == B_IDLE) && i_cmd_valid;
    assign o_tanh_start = (r_state == B_DRAIN) && !r_p1 && !r_p2;
    assign o_tanh_sum   = r_acc;

    // Sequencer: next state and counters.
    always_comb begin
        n_state  = r_state;
        n_layer  = r_layer;
        n_row    = r_row;
        n_col    = r_col;
        n_rows   = r_rows;
        n_cols   = r_cols;
        n_base   = r_base;
        n_waddr  = r_waddr;
        n_acc    = r_p2 ? r_acc + ACC_W'(r_prod) : r_acc;
        out_load = 1'b0;
        act_we   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && i_cmd.start) begin
                    n_state = B_MAC;
                    n_layer = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_rows  = CNT_W'(HIDDEN_WIDTH);
                    n_cols  = CNT_W'(INPUT_COUNT);
                    n_base  = '0;
                    n_waddr = '0;
                    n_acc   = '0;
                end
            end
            B_MAC: begin
                n_col   = r_col + 1'b1;
                n_waddr = r_waddr + WA'(r_rows);
                if (r_col == r_cols) n_state = B_DRAIN;
            end
            B_DRAIN: begin
                if (!r_p1 && !r_p2) n_state = B_TANH;
            end
            B_TANH: begin
                if (i_tanh_done) n_state = B_WRITE;
            end
            B_WRITE: begin
                if (!last_layer || !r_out_valid || o_out.ready) begin
                    out_load = last_layer;
                    act_we   = !last_layer;
                    n_col    = '0;
                    n_acc    = '0;
                    if (r_row + 1'b1 < r_rows) begin
                        n_row   = r_row + 1'b1;
                        n_waddr = r_base + WA'(r_row + 1'b1);
                        n_state = B_MAC;
                    end else if (last_layer) begin
                        n_state = B_IDLE;
                    end else begin
                        n_layer = r_layer + 1'b1;
                        n_row   = '0;
                        n_base  = base_next;
                        n_waddr = base_next;
                        n_rows  = (r_layer + 1'b1 == LAYER_W'(LAYER_COUNT)) ?
                                  CNT_W'(OUTPUT_COUNT) : CNT_W'(HIDDEN_WIDTH);
                        n_cols  = CNT_W'(HIDDEN_WIDTH);
                        n_state = B_MAC;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1    <= issue;
            r_p2    <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_layer <= n_layer;
        r_row   <= n_row;
        r_col   <= n_col;
        r_rows  <= n_rows;
        r_cols  <= n_cols;
        r_base  <= n_base;
        r_waddr <= n_waddr;
        r_acc   <= n_acc;
    end

    // Weight memory: command writes, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.wr_weight) r_wmem[WA'(i_cmd.addr)] <= i_cmd.value;
        r_wq <= r_wmem[r_waddr];
    end

    // Input vector memory.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.wr_input) r_imem[IW'(i_cmd.addr)] <= i_cmd.value;
        r_iq <= r_imem[IW'(r_col)];
    end

    // Activation memory: two halves, a layer writes one and reads the other.
    always_ff @(posedge i_clk) begin
        if (act_we) begin
            r_amem[{r_layer[0], AW'(r_row)}] <= VAL_W'(i_tanh_y);
        end
        r_aq <= r_amem[{!r_layer[0], AW'(r_col)}];
    end

    // Multiply stage.
    assign src = r_p1_bias ? ONE_Q12 :
                 (r_p1_hid ? 17'(r_aq) : 17'(r_iq));

    always_ff @(posedge i_clk) begin
        r_p1_bias <= (r_col == r_cols);
        r_p1_hid  <= (r_layer != '0);
        r_prod    <= r_wq * src;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index <= OUT_IDX_W'(r_row);
            r_out_value <= i_tanh_y;
            r_out_last  <= (r_row + 1'b1 == r_rows);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_index = r_out_index;
    assign o_out.out_value = r_out_value;
    assign o_out.out_last  = r_out_last;

endmodule
`default_nettype wire
